FILE: rtl/order_book_price_time_matcher_macros.svh
// assertion macros shared by the order matcher rtl
`ifndef ORDER_BOOK_PRICE_TIME_MATCHER_MACROS_SVH
`define ORDER_BOOK_PRICE_TIME_MATCHER_MACROS_SVH

// condition must hold at every clock edge outside reset
`define OBPTM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger implies the consequence on the next clock edge
`define OBPTM_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/obptm_pkg.sv
// shared types and constants for the order matcher
package obptm_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int OPL_DEF         = 8;
  localparam int MAX_RESULTS     = 64;
  localparam int IDX_W           = 6;
  localparam int CNT_W           = 7;

  typedef enum logic [2:0] {
    ST_UNFILLED = 3'd0,
    ST_PARTIAL  = 3'd1,
    ST_FILLED   = 3'd2,
    ST_ADDED    = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_NOP    = 3'd0,
    BK_READ   = 3'd1,
    BK_FILL   = 3'd2,
    BK_APPEND = 3'd3,
    BK_INSERT = 3'd4
  } book_op_t;

  typedef struct packed {
    book_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       price;
    logic [31:0]       id;
    logic [31:0]       qty;
  } book_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [31:0]       front_price;
    logic [31:0]       scan_price;
    logic [CNT_W-1:0]  scan_fill;
    logic [31:0]       rd_id;
    logic [31:0]       rd_qty;
  } book_stat_t;

endpackage

FILE: rtl/obptm_ram.sv
// generic single write port ram with registered read
module obptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: rtl/obptm_book.sv
// one side of the book: sorted level table over an order entry ram
module obptm_book #(
  parameter int LEVELS = obptm_pkg::LEVELS_DEF,
  parameter int OPL    = obptm_pkg::OPL_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  obptm_pkg::book_cmd_t   cmd,
  output obptm_pkg::book_stat_t  stat
);
  import obptm_pkg::*;
  `include "order_book_price_time_matcher_macros.svh"

  localparam int LW    = LEVELS > 1 ? $clog2(LEVELS) : 1;
  localparam int SW    = OPL > 1 ? $clog2(OPL) : 1;
  localparam int FW    = $clog2(OPL + 1);
  localparam int CW    = $clog2(LEVELS + 1);
  localparam int DEPTH = LEVELS * OPL;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [31:0]    price [LEVELS];
  logic [SW-1:0]  head  [LEVELS];
  logic [FW-1:0]  fill  [LEVELS];
  logic [LW-1:0]  row   [LEVELS];
  logic [CW-1:0]  count;
  logic [LEVELS-1:0] used;

  logic [LW-1:0]  idx;
  logic [LW-1:0]  free_row;
  logic [FW:0]    tsum;
  logic [SW-1:0]  app_slot;
  logic [SW:0]    hsum;
  logic [SW-1:0]  head_inc;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [63:0]    rd_data;

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] r, input logic [SW-1:0] s);
    addr_of = AW'(r) * AW'(OPL) + AW'(s);
  endfunction

  assign idx = cmd.idx[LW-1:0];

  // lowest free physical row
  always_comb begin
    free_row = '0;
    for (int j = LEVELS - 1; j >= 0; j--) begin
      if (!used[j]) free_row = LW'(j);
    end
  end

  // tail slot of the addressed level and next head of the front level
  always_comb begin
    tsum = (FW+1)'(head[idx]) + (FW+1)'(fill[idx]);
    if (tsum >= (FW+1)'(OPL)) tsum = tsum - (FW+1)'(OPL);
    app_slot = tsum[SW-1:0];
    hsum = (SW+1)'(head[0]) + (SW+1)'(1);
    if (hsum >= (SW+1)'(OPL)) hsum = '0;
    head_inc = hsum[SW-1:0];
  end

  // ram addressing
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_of(row[0], head[0]);
    rd_addr = addr_of(row[0], head[0]);
    case (cmd.op)
      BK_FILL:   wr_en = 1'b1;
      BK_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(row[idx], app_slot);
      end
      BK_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(free_row, '0);
      end
      default: wr_en = 1'b0;
    endcase
  end

  obptm_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({cmd.id, cmd.qty}),
    .rd_en   (cmd.op == BK_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // level table update
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= '0;
      for (int j = 0; j < LEVELS; j++) begin
        head[j] <= '0;
        fill[j] <= '0;
      end
    end else begin
      case (cmd.op)
        BK_FILL: begin
          if (cmd.qty == 32'd0) begin
            if (fill[0] == FW'(1)) begin
              // front level emptied: drop it
              used[row[0]] <= 1'b0;
              count        <= count - CW'(1);
              for (int j = 0; j < LEVELS - 1; j++) begin
                price[j] <= price[j+1];
                head[j]  <= head[j+1];
                fill[j]  <= fill[j+1];
                row[j]   <= row[j+1];
              end
            end else begin
              head[0] <= head_inc;
              fill[0] <= fill[0] - FW'(1);
            end
          end
        end
        BK_APPEND: fill[idx] <= fill[idx] + FW'(1);
        BK_INSERT: begin
          for (int j = 1; j < LEVELS; j++) begin
            if (CW'(j) > CW'(idx) && CW'(j) <= count) begin
              price[j] <= price[j-1];
              head[j]  <= head[j-1];
              fill[j]  <= fill[j-1];
              row[j]   <= row[j-1];
            end
          end
          price[idx]     <= cmd.price;
          head[idx]      <= '0;
          fill[idx]      <= FW'(1);
          row[idx]       <= free_row;
          used[free_row] <= 1'b1;
          count          <= count + CW'(1);
        end
        default: count <= count;
      endcase
    end
  end

  // status towards the sequencer
  always_comb begin
    stat.count       = CNT_W'(count);
    stat.front_price = price[0];
    stat.scan_price  = price[idx];
    stat.scan_fill   = CNT_W'(fill[idx]);
    stat.rd_id       = rd_data[63:32];
    stat.rd_qty      = rd_data[31:0];
  end

  `OBPTM_ASSERT_ALWAYS(a_count_max, count <= CW'(LEVELS), "level count beyond capacity")
  `OBPTM_ASSERT_ALWAYS(a_rows_match, $countones(used) == int'(count), "row usage differs from level count")
  `OBPTM_ASSERT_ALWAYS(a_front_nonempty, count == '0 || fill[0] != '0, "empty front level kept")
endmodule

FILE: rtl/order_book_price_time_matcher.sv
// Price-time priority matcher over a bid book and an ask book. Resting orders live in one
// entry ram per book, addressed through a small sorted level table; each match item walks the
// opposite book best level first. Every fill is a ram read in S_CHECK, then a modify and write
// back in S_READ; moving on to the next level needs no extra state. An add scans the level
// table one level per cycle, and a zero quantity add is rejected at once without a scan. A
// stalled result output holds the sequencer. One request is processed at a time; a trade
// result is held one fill back so the final one can carry last. No clearing pass is needed.
module order_book_price_time_matcher #(
  parameter int LEVELS           = obptm_pkg::LEVELS_DEF,
  parameter int ORDERS_PER_LEVEL = obptm_pkg::OPL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic        side,
  input  logic        order_kind,
  input  logic [31:0] order_id,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_trade,
  output logic [31:0] trade_id,
  output logic [31:0] buyer_id,
  output logic [31:0] seller_id,
  output logic [31:0] fill_quantity,
  output logic [31:0] fill_price,
  output logic [31:0] remaining_quantity,
  output logic [2:0]  order_status,
  output logic        last
);
  import obptm_pkg::*;
  `include "order_book_price_time_matcher_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_READ, S_FINISH, S_SCAN, S_DONE
  } state_t;

  state_t      state;
  logic        op_r, side_r, market_r;
  logic [31:0] id_r, limit_r, rem_r;
  logic [6:0]  k;
  logic [6:0]  scan_i;
  logic [31:0] trade_ctr;
  status_t     status_r;

  // held trade result
  logic        pend_valid;
  logic [31:0] pend_tid, pend_buyer, pend_seller, pend_fq, pend_fp, pend_rem;
  status_t     pend_status;

  book_cmd_t   cmd, ask_cmd, bid_cmd;
  book_stat_t  ask_stat, bid_stat, st;
  logic        use_ask;
  logic        out_free;
  logic        out_load;
  logic [31:0] tq, new_rem;
  logic        worse, new_level, fire_read;
  status_t     out_status;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign use_ask  = op_r ? side_r : !side_r;
  assign st       = use_ask ? ask_stat : bid_stat;
  assign order_status = out_status;

  // fill size and price check
  always_comb begin
    tq      = (rem_r < st.rd_qty) ? rem_r : st.rd_qty;
    new_rem = rem_r - tq;
    worse   = !market_r && (side_r ? (limit_r > st.front_price)
                                   : (limit_r < st.front_price));
    new_level = (scan_i == st.count) ||
                (side_r ? (limit_r < st.scan_price) : (limit_r > st.scan_price));
    fire_read = (st.count != '0) && (rem_r != 32'd0) &&
                (k != CNT_W'(MAX_RESULTS)) && !worse;
  end

  // result register load
  always_comb begin
    case (state)
      S_READ:   out_load = pend_valid && out_free;
      S_FINISH: out_load = out_free;
      S_DONE:   out_load = out_free;
      default:  out_load = 1'b0;
    endcase
  end

  // book command
  always_comb begin
    cmd       = '0;
    cmd.op    = BK_NOP;
    cmd.idx   = scan_i[IDX_W-1:0];
    cmd.price = limit_r;
    cmd.id    = id_r;
    cmd.qty   = rem_r;
    case (state)
      S_CHECK: if (fire_read) cmd.op = BK_READ;
      S_READ: begin
        if (!pend_valid || out_free) begin
          cmd.op  = BK_FILL;
          cmd.id  = st.rd_id;
          cmd.qty = st.rd_qty - tq;
        end
      end
      S_SCAN: begin
        if (new_level) begin
          if (st.count < CNT_W'(LEVELS)) cmd.op = BK_INSERT;
        end else if (st.scan_price == limit_r) begin
          if (st.scan_fill < CNT_W'(ORDERS_PER_LEVEL)) cmd.op = BK_APPEND;
        end
      end
      default: cmd.op = BK_NOP;
    endcase
    ask_cmd = cmd;
    bid_cmd = cmd;
    if (use_ask) bid_cmd.op = BK_NOP;
    else         ask_cmd.op = BK_NOP;
  end

  obptm_book #(.LEVELS(LEVELS), .OPL(ORDERS_PER_LEVEL)) u_ask (
    .clk (clk), .rst (rst), .cmd (ask_cmd), .stat (ask_stat)
  );

  obptm_book #(.LEVELS(LEVELS), .OPL(ORDERS_PER_LEVEL)) u_bid (
    .clk (clk), .rst (rst), .cmd (bid_cmd), .stat (bid_stat)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      trade_ctr  <= '0;
      k          <= '0;
      scan_i     <= '0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= operation;
            side_r   <= side;
            market_r <= order_kind;
            id_r     <= order_id;
            limit_r  <= limit_price;
            rem_r    <= order_quantity;
            k        <= '0;
            scan_i   <= '0;
            if (!operation) begin
              state <= S_CHECK;
            end else if (order_quantity == 32'd0) begin
              status_r <= ST_REJECTED;
              state    <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_CHECK: state <= fire_read ? S_READ : S_FINISH;
        S_READ: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              has_trade          <= 1'b1;
              trade_id           <= pend_tid;
              buyer_id           <= pend_buyer;
              seller_id          <= pend_seller;
              fill_quantity      <= pend_fq;
              fill_price         <= pend_fp;
              remaining_quantity <= pend_rem;
              out_status         <= pend_status;
              last               <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_tid    <= trade_ctr + 32'd1;
            pend_buyer  <= side_r ? st.rd_id : id_r;
            pend_seller <= side_r ? id_r : st.rd_id;
            pend_fq     <= tq;
            pend_fp     <= st.front_price;
            pend_rem    <= new_rem;
            pend_status <= (new_rem == 32'd0) ? ST_FILLED : ST_PARTIAL;
            trade_ctr   <= trade_ctr + 32'd1;
            k           <= k + 7'd1;
            rem_r       <= new_rem;
            state       <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            last      <= 1'b1;
            if (pend_valid) begin
              has_trade          <= 1'b1;
              trade_id           <= pend_tid;
              buyer_id           <= pend_buyer;
              seller_id          <= pend_seller;
              fill_quantity      <= pend_fq;
              fill_price         <= pend_fp;
              remaining_quantity <= pend_rem;
              out_status         <= pend_status;
            end else begin
              has_trade          <= 1'b0;
              trade_id           <= '0;
              buyer_id           <= '0;
              seller_id          <= '0;
              fill_quantity      <= '0;
              fill_price         <= '0;
              remaining_quantity <= rem_r;
              out_status         <= (rem_r == 32'd0) ? ST_FILLED : ST_UNFILLED;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (new_level) begin
            status_r <= (st.count < CNT_W'(LEVELS)) ? ST_ADDED : ST_REJECTED;
            state    <= S_DONE;
          end else if (st.scan_price == limit_r) begin
            status_r <= (st.scan_fill < CNT_W'(ORDERS_PER_LEVEL)) ? ST_ADDED : ST_REJECTED;
            state    <= S_DONE;
          end else begin
            scan_i <= scan_i + 7'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            has_trade          <= 1'b0;
            trade_id           <= '0;
            buyer_id           <= '0;
            seller_id          <= '0;
            fill_quantity      <= '0;
            fill_price         <= '0;
            remaining_quantity <= rem_r;
            out_status         <= status_r;
            last               <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OBPTM_ASSERT_ALWAYS(a_idle_no_pending, state != S_IDLE || !pend_valid, "held trade left over at idle")
  `OBPTM_ASSERT_ALWAYS(a_result_cap, k <= 7'(MAX_RESULTS), "trade count beyond result cap")
  `OBPTM_ASSERT_NEXT(a_fill_holds, state == S_READ && (!pend_valid || out_free), pend_valid && state == S_CHECK, "fill did not produce a held trade")
endmodule

FILE: bench/obptm_tb_pkg.sv
// request codes shared by the matcher testbench files
package obptm_tb_pkg;

  localparam logic OP_MATCH = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;

endpackage

FILE: bench/order_book_price_time_matcher_checker.sv
// book predictor and result checker for the order matcher
module order_book_price_time_matcher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic        side,
  input  logic        order_kind,
  input  logic [31:0] order_id,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_quantity,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        has_trade,
  input  logic [31:0] trade_id,
  input  logic [31:0] buyer_id,
  input  logic [31:0] seller_id,
  input  logic [31:0] fill_quantity,
  input  logic [31:0] fill_price,
  input  logic [31:0] remaining_quantity,
  input  logic [2:0]  order_status,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  import obptm_pkg::*;
  import obptm_tb_pkg::*;

  localparam int NLEV = LEVELS_DEF;
  localparam int NOPL = OPL_DEF;

  typedef struct {
    logic        trade;
    logic [31:0] tid;
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [31:0] fqty;
    logic [31:0] fprice;
    logic [31:0] remain;
    status_t     status;
    logic        fin;
  } fill_rec_t;

  // book copy, index 0 bids (falling price), 1 asks (rising price)
  logic [31:0] lvl_price [2][NLEV];
  int          lvl_count [2];
  logic [31:0] slot_id   [2][NLEV*NOPL];
  logic [31:0] slot_qty  [2][NLEV*NOPL];
  int          lvl_head  [2][NLEV];
  int          lvl_fill  [2][NLEV];
  logic [31:0] trade_seq;

  fill_rec_t expected_fills [$];

  function automatic void copy_level(int bk, int dst, int src);
    lvl_price[bk][dst] = lvl_price[bk][src];
    lvl_head[bk][dst] = lvl_head[bk][src];
    lvl_fill[bk][dst] = lvl_fill[bk][src];
    for (int j = 0; j < NOPL; j++) begin
      slot_id[bk][dst*NOPL+j] = slot_id[bk][src*NOPL+j];
      slot_qty[bk][dst*NOPL+j] = slot_qty[bk][src*NOPL+j];
    end
  endfunction

  function automatic status_t rest_order(int bk, logic [31:0] id, logic [31:0] px,
                                         logic [31:0] qty);
    int n;
    int pos;
    int s;
    n = lvl_count[bk];
    if (qty == 0) return ST_REJECTED;
    // existing level: append at the tail
    for (int i = 0; i < n; i++) begin
      if (lvl_price[bk][i] == px) begin
        if (lvl_fill[bk][i] >= NOPL) return ST_REJECTED;
        s = (lvl_head[bk][i] + lvl_fill[bk][i]) % NOPL;
        slot_id[bk][i*NOPL+s] = id;
        slot_qty[bk][i*NOPL+s] = qty;
        lvl_fill[bk][i]++;
        return ST_ADDED;
      end
    end
    if (n >= NLEV) return ST_REJECTED;
    // new level in sorted position
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (bk == 1 ? (px < lvl_price[bk][i]) : (px > lvl_price[bk][i])) begin
        pos = i;
        break;
      end
    end
    for (int i = n; i > pos; i--) copy_level(bk, i, i - 1);
    lvl_price[bk][pos] = px;
    lvl_head[bk][pos] = 0;
    lvl_fill[bk][pos] = 1;
    slot_id[bk][pos*NOPL] = id;
    slot_qty[bk][pos*NOPL] = qty;
    lvl_count[bk] = n + 1;
    return ST_ADDED;
  endfunction

  task automatic predict_request(logic op, logic sd, logic kind, logic [31:0] id,
                                 logic [31:0] lim, logic [31:0] qty);
    fill_rec_t r;
    int bk;
    int k;
    int s;
    logic [31:0] lp;
    logic [31:0] rq;
    logic [31:0] tq;
    logic [31:0] rem;
    r = '{1'b0, '0, '0, '0, '0, '0, '0, ST_UNFILLED, 1'b1};
    rem = qty;
    if (op == OP_ADD) begin
      r.remain = qty;
      r.status = rest_order(sd == SIDE_SELL ? 1 : 0, id, lim, qty);
      expected_fills.push_back(r);
      return;
    end
    bk = (sd == SIDE_BUY) ? 1 : 0;
    k = 0;
    // walk the opposite book best level first
    while (lvl_count[bk] > 0 && rem > 0 && k < MAX_RESULTS) begin
      lp = lvl_price[bk][0];
      if (kind == KIND_LIMIT) begin
        if (sd == SIDE_BUY && lim < lp) break;
        if (sd == SIDE_SELL && lim > lp) break;
      end
      while (lvl_fill[bk][0] > 0 && rem > 0 && k < MAX_RESULTS) begin
        s = lvl_head[bk][0] % NOPL;
        rq = slot_qty[bk][s];
        tq = (rem < rq) ? rem : rq;
        trade_seq = trade_seq + 1;
        rem = rem - tq;
        rq = rq - tq;
        slot_qty[bk][s] = rq;
        r.trade = 1'b1;
        r.tid = trade_seq;
        r.buyer = (sd == SIDE_BUY) ? id : slot_id[bk][s];
        r.seller = (sd == SIDE_BUY) ? slot_id[bk][s] : id;
        r.fqty = tq;
        r.fprice = lp;
        r.remain = rem;
        r.status = (rem == 0) ? ST_FILLED : ST_PARTIAL;
        r.fin = 1'b0;
        expected_fills.push_back(r);
        k++;
        if (rq == 0) begin
          lvl_head[bk][0] = (s + 1) % NOPL;
          lvl_fill[bk][0]--;
        end
      end
      if (lvl_fill[bk][0] == 0) begin
        for (int i = 1; i < lvl_count[bk]; i++) copy_level(bk, i - 1, i);
        lvl_count[bk]--;
      end else begin
        break;
      end
    end
    if (k == 0) begin
      r.remain = rem;
      r.status = (rem == 0) ? ST_FILLED : ST_UNFILLED;
      expected_fills.push_back(r);
    end else begin
      expected_fills[expected_fills.size()-1].fin = 1'b1;
    end
  endtask

  function automatic void check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", nm, exp_v, act_v);
    end
  endfunction

  // requests in, results out, compared in order
  always @(posedge clk) begin
    fill_rec_t e;
    if (rst) begin
      lvl_count[0] = 0;
      lvl_count[1] = 0;
      for (int i = 0; i < NLEV; i++) begin
        lvl_head[0][i] = 0;
        lvl_head[1][i] = 0;
        lvl_fill[0][i] = 0;
        lvl_fill[1][i] = 0;
      end
      trade_seq = '0;
      fail_count = 0;
      expected_fills.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_request(operation, side, order_kind, order_id, limit_price, order_quantity);
      if (out_valid && out_ready) begin
        if (expected_fills.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: trade_id %0d remaining %0d", trade_id,
                     remaining_quantity);
        end else begin
          e = expected_fills[0];
          expected_fills.delete(0);
          check_field("has_trade", 32'(e.trade), 32'(has_trade));
          check_field("trade_id", e.tid, trade_id);
          check_field("buyer_id", e.buyer, buyer_id);
          check_field("seller_id", e.seller, seller_id);
          check_field("fill_quantity", e.fqty, fill_quantity);
          check_field("fill_price", e.fprice, fill_price);
          check_field("remaining_quantity", e.remain, remaining_quantity);
          check_field("order_status", 32'(e.status), 32'(order_status));
          check_field("last", 32'(e.fin), 32'(last));
        end
      end
      pending <= expected_fills.size();
    end
  end

endmodule

FILE: bench/order_book_price_time_matcher_tb.sv
// stimulus, clocking and verdict for the order matcher
module order_book_price_time_matcher_tb;
  import obptm_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQUESTS = 224;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic        side = 1'b0;
  logic        order_kind = 1'b0;
  logic [31:0] order_id = '0;
  logic [31:0] limit_price = '0;
  logic [31:0] order_quantity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        has_trade;
  logic [31:0] trade_id;
  logic [31:0] buyer_id;
  logic [31:0] seller_id;
  logic [31:0] fill_quantity;
  logic [31:0] fill_price;
  logic [31:0] remaining_quantity;
  logic [2:0]  order_status;
  logic        last;
  int          fail_count;
  int          pending;
  int          cycle_no = 0;
  logic [31:0] mid_px;

  always #2 clk = ~clk;

  order_book_price_time_matcher u_top (.*);

  order_book_price_time_matcher_checker u_checker (.*);

  // offer one request and hold it until taken
  task automatic offer(logic op, logic sd, logic kind, logic [31:0] id, logic [31:0] px,
                       logic [31:0] qty);
    in_valid <= 1'b1;
    operation <= op;
    side <= sd;
    order_kind <= kind;
    order_id <= id;
    limit_price <= px;
    order_quantity <= qty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random request: mostly orders around a drifting mid, some noise
  task automatic offer_random();
    int pick;
    logic sd;
    pick = $urandom_range(0, 99);
    sd = 1'($urandom_range(0, 1));
    if (pick < 58)
      offer(OP_ADD, sd, 1'($urandom_range(0, 1)), $urandom, mid_px + $urandom_range(0, 9) - 4,
            $urandom_range(1, 20));
    else if (pick < 92)
      offer(OP_MATCH, sd, ($urandom_range(0, 3) == 0) ? KIND_MARKET : KIND_LIMIT, $urandom,
            mid_px + $urandom_range(0, 9) - 4, $urandom_range(1, 60));
    else
      offer(1'($urandom_range(0, 1)), sd, 1'($urandom_range(0, 1)), $urandom, $urandom,
            ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
  endtask

  // receiver: phased stall pattern plus one long hold-off
  initial begin
    int mode;
    forever begin
      @(posedge clk);
      cycle_no++;
      mode = (cycle_no / 700) % 3;
      if (cycle_no >= 1000 && cycle_no < 1400)
        out_ready <= 1'b0;
      else if (mode == 0)
        out_ready <= 1'b1;
      else if (mode == 1)
        out_ready <= ($urandom_range(0, 3) != 0);
      else
        out_ready <= ($urandom_range(0, 2) == 0);
    end
  end

  // run limit
  initial begin
    wait (cycle_no >= CYCLE_LIMIT);
    $display("[order_book_price_time_matcher] ERROR");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    mid_px = 32'd1000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty book, zero quantities, extremes
    offer(OP_MATCH, SIDE_BUY, KIND_LIMIT, 32'd1, 32'd100, 32'd5);
    offer(OP_MATCH, SIDE_SELL, KIND_MARKET, 32'd2, 32'd0, 32'd0);
    offer(OP_ADD, SIDE_SELL, KIND_LIMIT, 32'd3, 32'd100, 32'd0);
    offer(OP_ADD, SIDE_SELL, KIND_LIMIT, 32'd0, 32'd100, 32'd5);
    offer(OP_ADD, SIDE_SELL, KIND_MARKET, 32'hffff_ffff, 32'd100, 32'd3);
    offer(OP_ADD, SIDE_SELL, KIND_LIMIT, 32'd7, 32'd0, 32'd1);
    offer(OP_ADD, SIDE_SELL, KIND_LIMIT, 32'd8, 32'hffff_ffff, 32'hffff_ffff);
    offer(OP_ADD, SIDE_BUY, KIND_LIMIT, 32'd9, 32'd50, 32'd10);
    offer(OP_ADD, SIDE_BUY, KIND_LIMIT, 32'd10, 32'd0, 32'd2);
    // limit buy stops at the worse level
    offer(OP_MATCH, SIDE_BUY, KIND_LIMIT, 32'd11, 32'd99, 32'd4);
    offer(OP_MATCH, SIDE_BUY, KIND_MARKET, 32'd12, 32'd0, 32'd6);
    offer(OP_MATCH, SIDE_SELL, KIND_LIMIT, 32'd13, 32'hffff_ffff, 32'd20);
    offer(OP_MATCH, SIDE_SELL, KIND_MARKET, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // level full: ninth order at one price is rejected
    for (int i = 0; i < 9; i++)
      offer(OP_ADD, SIDE_BUY, KIND_LIMIT, 32'd20 + i, 32'd70, 32'd1 + i);
    offer(OP_MATCH, SIDE_SELL, KIND_LIMIT, 32'd40, 32'd70, 32'h8000_0000);
    offer(OP_MATCH, SIDE_BUY, KIND_MARKET, 32'd41, 32'd0, 32'hffff_ffff);

    // whole ask book filled, then swept by one market buy (result cap)
    for (int l = 0; l < 9; l++)
      for (int j = 0; j < 8; j++)
        offer(OP_ADD, SIDE_SELL, KIND_LIMIT, $urandom, 32'd500 + l, $urandom_range(1, 9));
    offer(OP_MATCH, SIDE_BUY, KIND_MARKET, $urandom, 32'd0, 32'hffff_ffff);

    // random bursts with gaps
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 10);
      for (int i = 0; i < burst; i++) begin
        offer_random();
        sent++;
      end
      if ($urandom_range(0, 15) == 0) mid_px = $urandom_range(10, 100000);
      pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("[order_book_price_time_matcher] OK");
    else
      $display("[order_book_price_time_matcher] ERROR");
    $finish;
  end

endmodule
